[design/bse_pkg.sv]
// bse_pkg: shared types, codes and box geometry helpers for the box suppression engine
// no dependencies; used by the interfaces and every module of the block but bse_ram
`default_nettype none

package bse_pkg;

   localparam int COORD_W = 12;
   localparam int SIZE_W  = 13;
   localparam int EDGE_W  = 14;   // x + width
   localparam int AREA_W  = 26;   // width * height
   localparam int INTER_W = 28;   // product of the x and y edge differences
   localparam int CMP_W   = 35;   // percent-scaled overlap and union
   localparam int MINA_W  = 25;
   localparam int THR_W   = 7;
   localparam int DROP_W  = 8;
   localparam int CNT_W   = 7;    // holds counts up to the largest store size
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;
   localparam int RESULT_LIMIT = 32;
   localparam int KEPT_W      = 6;
   localparam int IOU_SCALE   = 100;
   localparam logic [MINA_W-1:0] MIN_AREA_RESET = 25'd400;
   localparam logic [THR_W-1:0]  IOU_THR_RESET  = 7'd1;

   localparam logic [1:0] CMD_CLEAR     = 2'd0;
   localparam logic [1:0] CMD_LOAD_CAND = 2'd1;
   localparam logic [1:0] CMD_LOAD_TRK  = 2'd2;
   localparam logic [1:0] CMD_RUN       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_AREA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THR  = 2'd1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [SIZE_W-1:0]  w;
      logic [SIZE_W-1:0]  h;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   // snapshot of the frame taken when a run beat is accepted
   typedef struct packed {
      logic [CNT_W-1:0]  ncand;
      logic [CNT_W-1:0]  ntrk;
      logic [DROP_W-1:0] dropped;
   } run_type;

   function automatic logic [AREA_W-1:0] box_area(input box_type b);
      box_area = AREA_W'(b.w) * AREA_W'(b.h);
   endfunction

   function automatic logic [INTER_W-1:0] overlap_area(input box_type a, input box_type b);
      logic [COORD_W-1:0] x1, y1;
      logic [EDGE_W-1:0]  ax2, bx2, ay2, by2, x2, y2, dx, dy;
      x1  = (a.x > b.x) ? a.x : b.x;
      y1  = (a.y > b.y) ? a.y : b.y;
      ax2 = EDGE_W'(a.x) + EDGE_W'(a.w);
      bx2 = EDGE_W'(b.x) + EDGE_W'(b.w);
      ay2 = EDGE_W'(a.y) + EDGE_W'(a.h);
      by2 = EDGE_W'(b.y) + EDGE_W'(b.h);
      x2  = (ax2 < bx2) ? ax2 : bx2;
      y2  = (ay2 < by2) ? ay2 : by2;
      dx  = x2 - EDGE_W'(x1);
      dy  = y2 - EDGE_W'(y1);
      if (x2 <= EDGE_W'(x1) || y2 <= EDGE_W'(y1)) begin
         overlap_area = '0;
      end else begin
         overlap_area = INTER_W'(dx) * INTER_W'(dy);
      end
   endfunction

endpackage

`default_nettype wire

[design/bse_if.sv]
// channel interfaces of the box suppression engine: request, response and register write
// depends on bse_pkg for field widths
`default_nettype none

interface bse_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        command;
   logic [bse_pkg::COORD_W-1:0]       box_x;
   logic [bse_pkg::COORD_W-1:0]       box_y;
   logic [bse_pkg::SIZE_W-1:0]        box_width;
   logic [bse_pkg::SIZE_W-1:0]        box_height;
   modport source (output valid, command, box_x, box_y, box_width, box_height, input ready);
   modport sink   (input valid, command, box_x, box_y, box_width, box_height, output ready);
endinterface

interface bse_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bse_pkg::COORD_W-1:0]       kept_x;
   logic [bse_pkg::COORD_W-1:0]       kept_y;
   logic [bse_pkg::SIZE_W-1:0]        kept_width;
   logic [bse_pkg::SIZE_W-1:0]        kept_height;
   logic                              kept_valid;
   logic                              last_of_run;
   logic [bse_pkg::DROP_W-1:0]        dropped_count;
   modport source (output valid, kept_x, kept_y, kept_width, kept_height, kept_valid,
                   last_of_run, dropped_count, input ready);
   modport sink   (input valid, kept_x, kept_y, kept_width, kept_height, kept_valid,
                   last_of_run, dropped_count, output ready);
endinterface

interface bse_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bse_pkg::CSR_IDX_W-1:0]     index;
   logic [bse_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/bse_ram.sv]
// bse_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module bse_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[design/bse_front.sv]
// bse_front: accepts request beats, holds the registers and counts, loads the box stores
// and queues run beats; depends on bse_pkg and bse_if
`default_nettype none

module bse_front #(
   parameter int MAX_CANDIDATES = 32,
   parameter int MAX_TRACKERS   = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bse_req_if.sink                                  req_bus,
   bse_csr_if.sink                                  csr_bus,
   input  wire logic                                q_full,
   input  wire logic                                q_empty,
   input  wire logic                                back_busy,
   output logic                                     q_push,
   output bse_pkg::run_type                         q_data,
   output logic                                     cand_wr_en,
   output logic [$clog2(MAX_CANDIDATES)-1:0]        cand_wr_addr,
   output logic                                     trk_wr_en,
   output logic [(MAX_TRACKERS > 1 ? $clog2(MAX_TRACKERS) : 1)-1:0] trk_wr_addr,
   output bse_pkg::box_type                         box_data,
   output logic [bse_pkg::THR_W-1:0]                iou_thr
);

   localparam int CCW = $clog2(MAX_CANDIDATES + 1);
   localparam int TCW = $clog2(MAX_TRACKERS + 1);
   localparam int CIW = $clog2(MAX_CANDIDATES);
   localparam int TIW = MAX_TRACKERS > 1 ? $clog2(MAX_TRACKERS) : 1;

   logic [CCW-1:0]                ncand_ff, ncand_in;
   logic [TCW-1:0]                ntrk_ff, ntrk_in;
   logic [bse_pkg::DROP_W-1:0]    drop_ff, drop_in;
   logic [bse_pkg::MINA_W-1:0]    min_area_ff;
   logic [bse_pkg::THR_W-1:0]     thr_ff;
   logic                          accept;
   logic                          big_enough;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      box_data.x = req_bus.box_x;
      box_data.y = req_bus.box_y;
      box_data.w = req_bus.box_width;
      box_data.h = req_bus.box_height;
   end

   // loads and clears wait until the back has finished with the stores
   assign req_bus.ready = (req_bus.command == bse_pkg::CMD_RUN) ? !q_full
                                                                 : (q_empty && !back_busy);
   assign accept     = req_bus.valid && req_bus.ready;
   assign big_enough = bse_pkg::box_area(box_data) >= bse_pkg::AREA_W'(min_area_ff);

   assign cand_wr_en   = accept && req_bus.command == bse_pkg::CMD_LOAD_CAND && big_enough
                         && ncand_ff < CCW'(MAX_CANDIDATES);
   assign cand_wr_addr = ncand_ff[CIW-1:0];
   assign trk_wr_en    = accept && req_bus.command == bse_pkg::CMD_LOAD_TRK
                         && ntrk_ff < TCW'(MAX_TRACKERS);
   assign trk_wr_addr  = TIW'(ntrk_ff);
   assign iou_thr      = thr_ff;

   assign q_push        = accept && req_bus.command == bse_pkg::CMD_RUN;
   assign q_data.ncand  = bse_pkg::CNT_W'(ncand_ff);
   assign q_data.ntrk   = bse_pkg::CNT_W'(ntrk_ff);
   assign q_data.dropped = drop_ff;

   always_comb begin
      ncand_in = ncand_ff;
      ntrk_in  = ntrk_ff;
      drop_in  = drop_ff;
      if (accept) begin
         case (req_bus.command)
            bse_pkg::CMD_CLEAR: begin
               ncand_in = '0;
               ntrk_in  = '0;
               drop_in  = '0;
            end
            bse_pkg::CMD_LOAD_CAND: begin
               if (cand_wr_en) begin
                  ncand_in = ncand_ff + 1'b1;
               end else if (big_enough && drop_ff != '1) begin
                  drop_in = drop_ff + 1'b1;
               end
            end
            bse_pkg::CMD_LOAD_TRK: begin
               if (trk_wr_en) begin
                  ntrk_in = ntrk_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncand_ff    <= '0;
         ntrk_ff     <= '0;
         drop_ff     <= '0;
         min_area_ff <= bse_pkg::MIN_AREA_RESET;
         thr_ff      <= bse_pkg::IOU_THR_RESET;
      end else begin
         ncand_ff <= ncand_in;
         ntrk_ff  <= ntrk_in;
         drop_ff  <= drop_in;
         if (csr_bus.valid) begin
            if (csr_bus.index == bse_pkg::CSR_MIN_AREA) begin
               min_area_ff <= csr_bus.data;
            end else if (csr_bus.index == bse_pkg::CSR_IOU_THR) begin
               thr_ff <= csr_bus.data[bse_pkg::THR_W-1:0];
            end
         end
      end
   end

endmodule

`default_nettype wire

[design/bse_run_fifo.sv]
// bse_run_fifo: two-entry queue of run snapshots between the front and the back
// depends on bse_pkg
`default_nettype none

module bse_run_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bse_pkg::run_type  push_data,
   input  wire logic              pop,
   output bse_pkg::run_type       pop_data,
   output logic                   full,
   output logic                   empty
);

   bse_pkg::run_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

[design/bse_back.sv]
// bse_back: run sequencer; ranks candidates into the sorted store, then containment,
// tracker overlap and greedy iou passes, one box pair at a time; depends on bse_pkg, bse_if
`default_nettype none

module bse_back #(
   parameter int MAX_CANDIDATES = 32,
   parameter int MAX_TRACKERS   = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_empty,
   input  wire bse_pkg::run_type                    q_data,
   output logic                                     q_pop,
   output logic                                     busy,
   input  wire logic [bse_pkg::THR_W-1:0]           iou_thr,
   output logic [$clog2(MAX_CANDIDATES)-1:0]        cand_rd_addr,
   input  wire bse_pkg::box_type                    cand_rd_data,
   output logic [(MAX_TRACKERS > 1 ? $clog2(MAX_TRACKERS) : 1)-1:0] trk_rd_addr,
   input  wire bse_pkg::box_type                    trk_rd_data,
   output logic                                     sort_wr_en,
   output logic [$clog2(MAX_CANDIDATES)-1:0]        sort_wr_addr,
   output bse_pkg::box_type                         sort_wr_data,
   output logic [$clog2(MAX_CANDIDATES)-1:0]        sort_rd_addr,
   input  wire bse_pkg::box_type                    sort_rd_data,
   bse_rsp_if.source                                rsp_bus
);

   localparam int CW  = $clog2((MAX_CANDIDATES > MAX_TRACKERS ? MAX_CANDIDATES
                                                              : MAX_TRACKERS) + 1);
   localparam int CIW = $clog2(MAX_CANDIDATES);
   localparam int TIW = MAX_TRACKERS > 1 ? $clog2(MAX_TRACKERS) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_A_RD  = 4'd1;
   localparam logic [3:0] S_A_CAP = 4'd2;
   localparam logic [3:0] S_J_RD  = 4'd3;
   localparam logic [3:0] S_J_C1  = 4'd4;
   localparam logic [3:0] S_J_C2  = 4'd5;
   localparam logic [3:0] S_O_END = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;
   localparam logic [3:0] S_FLUSH = 4'd8;

   localparam logic [1:0] PH_SORT   = 2'd0;
   localparam logic [1:0] PH_CONT   = 2'd1;
   localparam logic [1:0] PH_TRK    = 2'd2;
   localparam logic [1:0] PH_GREEDY = 2'd3;

   logic [3:0]                     state_ff, state_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [CW-1:0]                  i_ff, i_in, j_ff, j_in, n_ff, n_in, nt_ff, nt_in;
   logic [CW-1:0]                  rank_ff, rank_in, outer_lim;
   logic [bse_pkg::DROP_W-1:0]     drop_ff, drop_in;
   bse_pkg::box_type               a_ff, a_in, pend_ff, pend_in, s_box, a_src;
   logic                           pend_v_ff, pend_v_in;
   logic [bse_pkg::AREA_W-1:0]     area_a_ff, area_a_in, area_s_ff, area_s_in;
   logic [bse_pkg::INTER_W-1:0]    inter_ff, inter_in, uni;
   logic [bse_pkg::CMP_W-1:0]      lhs, rhs;
   logic [MAX_CANDIDATES-1:0]      alive_ff, alive_in;
   logic [bse_pkg::KEPT_W-1:0]     kept_ff, kept_in;
   logic                           out_v_ff, out_v_in, out_free;
   bse_pkg::box_type               out_box_ff, out_box_in;
   logic                           out_kv_ff, out_kv_in, out_last_ff, out_last_in;
   logic [bse_pkg::DROP_W-1:0]     out_drop_ff, out_drop_in;

   assign busy       = state_ff != S_IDLE;
   assign outer_lim  = (phase_ff == PH_TRK) ? nt_ff : n_ff;
   assign out_free   = !out_v_ff || rsp_bus.ready;

   assign cand_rd_addr = (state_ff == S_A_RD) ? i_ff[CIW-1:0] : j_ff[CIW-1:0];
   assign sort_rd_addr = (state_ff == S_A_RD) ? i_ff[CIW-1:0] : j_ff[CIW-1:0];
   assign trk_rd_addr  = TIW'(i_ff);
   assign sort_wr_en   = state_ff == S_O_END && phase_ff == PH_SORT;
   assign sort_wr_addr = rank_ff[CIW-1:0];
   assign sort_wr_data = a_ff;

   assign a_src = (phase_ff == PH_SORT) ? cand_rd_data :
                  (phase_ff == PH_TRK)  ? trk_rd_data  : sort_rd_data;
   assign s_box = (phase_ff == PH_SORT) ? cand_rd_data : sort_rd_data;

   assign uni = bse_pkg::INTER_W'(area_a_ff) + bse_pkg::INTER_W'(area_s_ff) - inter_ff;
   assign lhs = bse_pkg::CMP_W'(inter_ff) * bse_pkg::CMP_W'(bse_pkg::IOU_SCALE);
   assign rhs = bse_pkg::CMP_W'(iou_thr) * bse_pkg::CMP_W'(uni);

   assign q_pop = state_ff == S_IDLE && !q_empty;

   assign rsp_bus.valid         = out_v_ff;
   assign rsp_bus.kept_x        = out_box_ff.x;
   assign rsp_bus.kept_y        = out_box_ff.y;
   assign rsp_bus.kept_width    = out_box_ff.w;
   assign rsp_bus.kept_height   = out_box_ff.h;
   assign rsp_bus.kept_valid    = out_kv_ff;
   assign rsp_bus.last_of_run   = out_last_ff;
   assign rsp_bus.dropped_count = out_drop_ff;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      n_in        = n_ff;
      nt_in       = nt_ff;
      rank_in     = rank_ff;
      drop_in     = drop_ff;
      a_in        = a_ff;
      area_a_in   = area_a_ff;
      area_s_in   = area_s_ff;
      inter_in    = inter_ff;
      alive_in    = alive_ff;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      kept_in     = kept_ff;
      out_v_in    = out_v_ff && !rsp_bus.ready;
      out_box_in  = out_box_ff;
      out_kv_in   = out_kv_ff;
      out_last_in = out_last_ff;
      out_drop_in = out_drop_ff;

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               n_in      = CW'(q_data.ncand);
               nt_in     = CW'(q_data.ntrk);
               drop_in   = q_data.dropped;
               alive_in  = '1;
               phase_in  = PH_SORT;
               i_in      = '0;
               pend_v_in = 1'b0;
               kept_in   = '0;
               state_in  = S_A_RD;
            end
         end
         S_A_RD: begin
            if (i_ff >= outer_lim) begin
               i_in = '0;
               case (phase_ff)
                  PH_SORT:   phase_in = PH_CONT;
                  PH_CONT:   phase_in = PH_TRK;
                  PH_TRK:    phase_in = PH_GREEDY;
                  default:   state_in = S_FLUSH;
               endcase
            end else if ((phase_ff == PH_CONT || phase_ff == PH_GREEDY)
                         && !alive_ff[i_ff[CIW-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = S_A_CAP;
            end
         end
         S_A_CAP: begin
            a_in      = a_src;
            area_a_in = bse_pkg::box_area(a_src);
            rank_in   = '0;
            j_in      = (phase_ff == PH_SORT || phase_ff == PH_TRK) ? '0 : i_ff + 1'b1;
            state_in  = S_J_RD;
         end
         S_J_RD: begin
            if (j_ff >= n_ff) begin
               state_in = S_O_END;
            end else if (phase_ff != PH_SORT && !alive_ff[j_ff[CIW-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = S_J_C1;
            end
         end
         S_J_C1: begin
            inter_in  = bse_pkg::overlap_area(a_ff, s_box);
            area_s_in = bse_pkg::box_area(s_box);
            state_in  = S_J_C2;
         end
         S_J_C2: begin
            case (phase_ff)
               PH_SORT: begin
                  // stable descending order: larger areas, then equal areas loaded earlier
                  if (area_s_ff > area_a_ff || (area_s_ff == area_a_ff && j_ff < i_ff)) begin
                     rank_in = rank_ff + 1'b1;
                  end
               end
               PH_CONT: begin
                  if (inter_ff == bse_pkg::INTER_W'(area_s_ff)) begin
                     alive_in[j_ff[CIW-1:0]] = 1'b0;
                  end
               end
               PH_TRK: begin
                  if (inter_ff != '0) begin
                     alive_in[j_ff[CIW-1:0]] = 1'b0;
                  end
               end
               default: begin
                  if (inter_ff != '0 && lhs > rhs) begin
                     alive_in[j_ff[CIW-1:0]] = 1'b0;
                  end
               end
            endcase
            j_in     = j_ff + 1'b1;
            state_in = S_J_RD;
         end
         S_O_END: begin
            i_in     = i_ff + 1'b1;
            state_in = S_A_RD;
            if (phase_ff == PH_GREEDY && kept_ff < bse_pkg::KEPT_W'(bse_pkg::RESULT_LIMIT)) begin
               kept_in = kept_ff + 1'b1;
               if (pend_v_ff) begin
                  // the previous kept box goes out once a later one is known
                  i_in     = i_ff;
                  state_in = S_EMIT;
               end else begin
                  pend_in   = a_ff;
                  pend_v_in = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_box_in  = pend_ff;
               out_kv_in   = 1'b1;
               out_last_in = 1'b0;
               out_drop_in = drop_ff;
               pend_in     = a_ff;
               i_in        = i_ff + 1'b1;
               state_in    = S_A_RD;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_box_in  = pend_v_ff ? pend_ff : '0;
               out_kv_in   = pend_v_ff;
               out_last_in = 1'b1;
               out_drop_in = drop_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      n_ff        <= n_in;
      nt_ff       <= nt_in;
      rank_ff     <= rank_in;
      drop_ff     <= drop_in;
      a_ff        <= a_in;
      area_a_ff   <= area_a_in;
      area_s_ff   <= area_s_in;
      inter_ff    <= inter_in;
      alive_ff    <= alive_in;
      pend_ff     <= pend_in;
      kept_ff     <= kept_in;
      out_box_ff  <= out_box_in;
      out_kv_ff   <= out_kv_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

endmodule

`default_nettype wire

[design/box_suppression_engine_top.sv]
// box_suppression_engine_top: top level, front, run queue, back and the three box rams
// depends on bse_pkg, bse_if, bse_ram, bse_front, bse_run_fifo, bse_back
`default_nettype none

// Greedy box suppression for one frame. Clear, candidate load and tracker load beats return
// nothing; a candidate whose area is below min_area is rejected, one that finds the store
// full bumps the saturating dropped count. A run beat returns the kept boxes in descending
// area order, the last flagged last_of_run, or a single empty result if nothing is kept.
// A run is a sequencer that visits one box pair at a time through the single read port of
// each box ram. Loads and clears that follow a run wait until it is done; a second run beat
// can queue behind it.
module box_suppression_engine_top #(
   parameter int MAX_CANDIDATES = 32,
   parameter int MAX_TRACKERS   = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   bse_req_if.sink      req_bus,
   bse_rsp_if.source    rsp_bus,
   bse_csr_if.sink      csr_bus
);

   localparam int CIW = $clog2(MAX_CANDIDATES);
   localparam int TIW = MAX_TRACKERS > 1 ? $clog2(MAX_TRACKERS) : 1;

   logic                         q_full, q_empty, q_push, q_pop, back_busy;
   bse_pkg::run_type             q_wr, q_rd;
   logic                         cand_wr_en, trk_wr_en, sort_wr_en;
   logic [CIW-1:0]               cand_wr_addr, cand_rd_addr, sort_wr_addr, sort_rd_addr;
   logic [TIW-1:0]               trk_wr_addr, trk_rd_addr;
   bse_pkg::box_type             box_data, cand_rd_data, trk_rd_data, sort_wr_data;
   bse_pkg::box_type             sort_rd_data;
   logic [bse_pkg::THR_W-1:0]    iou_thr;

   bse_front #(.MAX_CANDIDATES(MAX_CANDIDATES), .MAX_TRACKERS(MAX_TRACKERS)) u_front (
      .clock, .reset, .req_bus, .csr_bus,
      .q_full, .q_empty, .back_busy, .q_push, .q_data(q_wr),
      .cand_wr_en, .cand_wr_addr, .trk_wr_en, .trk_wr_addr, .box_data, .iou_thr
   );

   bse_run_fifo u_fifo (
      .clock, .reset, .push(q_push), .push_data(q_wr), .pop(q_pop), .pop_data(q_rd),
      .full(q_full), .empty(q_empty)
   );

   bse_ram #(.WIDTH(bse_pkg::BOX_W), .DEPTH(MAX_CANDIDATES)) u_cand_ram (
      .clock, .wr_en(cand_wr_en), .wr_addr(cand_wr_addr), .wr_data(box_data),
      .rd_addr(cand_rd_addr), .rd_data(cand_rd_data)
   );

   bse_ram #(.WIDTH(bse_pkg::BOX_W), .DEPTH(MAX_TRACKERS)) u_trk_ram (
      .clock, .wr_en(trk_wr_en), .wr_addr(trk_wr_addr), .wr_data(box_data),
      .rd_addr(trk_rd_addr), .rd_data(trk_rd_data)
   );

   bse_ram #(.WIDTH(bse_pkg::BOX_W), .DEPTH(MAX_CANDIDATES)) u_sort_ram (
      .clock, .wr_en(sort_wr_en), .wr_addr(sort_wr_addr), .wr_data(sort_wr_data),
      .rd_addr(sort_rd_addr), .rd_data(sort_rd_data)
   );

   bse_back #(.MAX_CANDIDATES(MAX_CANDIDATES), .MAX_TRACKERS(MAX_TRACKERS)) u_back (
      .clock, .reset, .q_empty, .q_data(q_rd), .q_pop, .busy(back_busy), .iou_thr,
      .cand_rd_addr, .cand_rd_data, .trk_rd_addr, .trk_rd_data,
      .sort_wr_en, .sort_wr_addr, .sort_wr_data, .sort_rd_addr, .sort_rd_data, .rsp_bus
   );

endmodule

`default_nettype wire
